### hw/rtl/slcr_pkg.sv
// ----------------------------------------------------------------------------
// slcr_pkg
// Shared types, register map, reset values and send tables for the
// steering-lock bus responder.
// ----------------------------------------------------------------------------
package slcr_pkg;

  // Register map of the configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_IVL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_IVL  = 3'd5;

  // Register reset values
  localparam logic [10:0] RST_LISTEN_ID = 11'h505;
  localparam logic [10:0] RST_SEND_ID   = 11'h581;
  localparam logic [7:0]  RST_PRESENT   = 8'h44;
  localparam logic [7:0]  RST_ABSENT    = 8'h04;
  localparam logic [7:0]  RST_FAST_IVL  = 8'd22;
  localparam logic [7:0]  RST_SLOW_IVL  = 8'd100;

  // Input commands
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Length code of a key report frame
  localparam logic [3:0] KEY_FRAME_LEN = 4'd4;

  // Result queue depth (one update sends at most two frames)
  localparam int QUEUE_DEPTH = 2;

  // Sequence step, stored as step index plus one
  typedef logic [2:0] step_t;
  localparam step_t STEP_START = 3'd0;
  localparam step_t STEP_0     = 3'd1;
  localparam step_t STEP_1     = 3'd2;
  localparam step_t STEP_2     = 3'd3;
  localparam step_t STEP_3     = 3'd4;
  localparam step_t STEP_4     = 3'd5;
  localparam step_t STEP_5     = 3'd6;
  localparam step_t STEP_6     = 3'd7;

  // Frame data, byte 0 in the top byte
  localparam logic [31:0] DATA_A0 = 32'h02A0_0203;
  localparam logic [31:0] DATA_A1 = 32'h8220_0003;
  localparam logic [31:0] DATA_A2 = 32'h0220_0003;
  localparam logic [31:0] DATA_P0 = 32'h0220_0083;
  localparam logic [31:0] DATA_P1 = 32'h8010_0083;
  localparam logic [31:0] DATA_P2 = 32'h0008_0483;
  localparam logic [31:0] DATA_P3 = 32'h8010_0083;
  localparam logic [31:0] DATA_P4 = 32'h0010_0083;
  localparam logic [31:0] DATA_L0 = 32'h8810_0083;
  localparam logic [31:0] DATA_L1 = 32'h0810_0083;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  frame_byte2;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] tx_id;
    logic [7:0]  tx_byte0;
    logic [7:0]  tx_byte1;
    logic [7:0]  tx_byte2;
    logic [7:0]  tx_byte3;
    logic        last_frame;
  } out_beat_t;

  typedef struct packed {
    logic [10:0] listen_id;
    logic [10:0] send_id;
    logic [7:0]  present_code;
    logic [7:0]  absent_code;
    logic [7:0]  fast_interval_ms;
    logic [7:0]  slow_interval_ms;
  } cfg_t;

  // Frames produced by the item in the input register
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  frame0;
    out_beat_t  frame1;
  } resp_t;

  // What one firing step does
  typedef struct packed {
    logic [1:0]  cnt;
    logic [31:0] d0;
    logic [31:0] d1;
    logic        slow;
    step_t       nxt;
  } plan_t;

  function automatic plan_t step_plan(input logic present, input step_t step);
    plan_t p;
    p = '{cnt: 2'd0, d0: DATA_A0, d1: DATA_L0, slow: 1'b0, nxt: STEP_0};
    if (!present) begin
      case (step)
        STEP_START: begin p.cnt = 2'd1; p.d0 = DATA_A0; p.nxt = STEP_0; end
        STEP_0:     begin p.cnt = 2'd1; p.d0 = DATA_A1; p.nxt = STEP_1; end
        STEP_1:     begin p.cnt = 2'd1; p.d0 = DATA_A2; p.nxt = STEP_0; end
        default:    begin p.cnt = 2'd0; p.nxt = STEP_0; end
      endcase
    end else begin
      case (step)
        STEP_START: begin p.cnt = 2'd0; p.nxt = STEP_0; end
        STEP_0:     begin p.cnt = 2'd1; p.d0 = DATA_P0; p.nxt = STEP_1; end
        STEP_1:     begin p.cnt = 2'd1; p.d0 = DATA_P1; p.nxt = STEP_2; end
        STEP_2:     begin p.cnt = 2'd1; p.d0 = DATA_P2; p.nxt = STEP_3; end
        STEP_3:     begin p.cnt = 2'd1; p.d0 = DATA_P3; p.nxt = STEP_4; end
        STEP_4: begin
          p.cnt  = 2'd2;
          p.d0   = DATA_P4;
          p.d1   = DATA_L0;
          p.slow = 1'b1;
          p.nxt  = STEP_5;
        end
        STEP_5:     begin p.cnt = 2'd1; p.d0 = DATA_L1; p.nxt = STEP_6; end
        default:    begin p.cnt = 2'd1; p.d0 = DATA_L0; p.nxt = STEP_5; end
      endcase
    end
    return p;
  endfunction

  function automatic out_beat_t make_beat(input logic [10:0] id, input logic [31:0] data,
                                          input logic last);
    out_beat_t b;
    b.tx_id      = id;
    b.tx_byte0   = data[31:24];
    b.tx_byte1   = data[23:16];
    b.tx_byte2   = data[15:8];
    b.tx_byte3   = data[7:0];
    b.last_frame = last;
    return b;
  endfunction

endpackage

### hw/rtl/slcr_seq.sv
// ----------------------------------------------------------------------------
// slcr_seq
// Send sequencer: holds mode, step, deadline and interval, decodes the item
// in the input register and updates state when the item is retired.
// ----------------------------------------------------------------------------
module slcr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  slcr_pkg::in_beat_t item,
  input  logic              item_go,
  input  slcr_pkg::cfg_t    cfg,
  output slcr_pkg::resp_t   resp
);
  import slcr_pkg::*;

  logic        key_present_r, key_present_nxt;
  step_t       step_r, step_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [7:0]  interval_r, interval_nxt;

  logic        key_frame;
  logic        fire;
  plan_t       plan;
  logic [7:0]  ivl_sel;

  // Decode
  always_comb begin
    key_frame = (item.command == CMD_FRAME) && (item.frame_id == cfg.listen_id) &&
                (item.frame_len == KEY_FRAME_LEN);
    fire      = (item.command == CMD_TICK) && !(item.now_ms < deadline_r);
    plan      = step_plan(key_present_r, step_r);
    ivl_sel   = plan.slow ? cfg.slow_interval_ms : interval_r;

    resp.cnt    = fire ? plan.cnt : 2'd0;
    resp.frame0 = make_beat(cfg.send_id, plan.d0, plan.cnt == 2'd1);
    resp.frame1 = make_beat(cfg.send_id, plan.d1, 1'b1);
  end

  // Next state, taken only when the item retires
  always_comb begin
    key_present_nxt = key_present_r;
    step_nxt        = step_r;
    deadline_nxt    = deadline_r;
    interval_nxt    = interval_r;
    if (item_go) begin
      if (key_frame) begin
        step_nxt     = STEP_0;
        deadline_nxt = 32'd0;
        interval_nxt = cfg.fast_interval_ms;
        if (item.frame_byte2 == cfg.present_code) begin
          key_present_nxt = 1'b1;
        end else if (item.frame_byte2 == cfg.absent_code) begin
          key_present_nxt = 1'b0;
        end
      end else if (fire) begin
        step_nxt     = plan.nxt;
        interval_nxt = ivl_sel;
        deadline_nxt = item.now_ms + {24'd0, ivl_sel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_present_r <= 1'b0;
      step_r        <= STEP_START;
      deadline_r    <= 32'd0;
      interval_r    <= 8'd0;
    end else begin
      key_present_r <= key_present_nxt;
      step_r        <= step_nxt;
      deadline_r    <= deadline_nxt;
      interval_r    <= interval_nxt;
    end
  end

endmodule

### hw/rtl/slcr_txq.sv
// ----------------------------------------------------------------------------
// slcr_txq
// Two-entry result queue: takes zero, one or two frames per cycle and
// presents one beat per cycle on the result channel, held while out_ready is low.
// ----------------------------------------------------------------------------
module slcr_txq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slcr_pkg::resp_t    resp,
  output logic [1:0]         free_slots,
  output logic               out_valid,
  input  logic               out_ready,
  output slcr_pkg::out_beat_t out_data
);
  import slcr_pkg::*;

  out_beat_t  q_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] push_n;
  logic       pop;

  // Pointer and fill bookkeeping
  always_comb begin
    out_valid  = (cnt_r != 2'd0);
    out_data   = q_r[rd_ptr_r];
    push_n     = push ? resp.cnt : 2'd0;
    pop        = out_valid && out_ready;
    wr_ptr_nxt = wr_ptr_r ^ push_n[0];
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + push_n - {1'b0, pop};
    free_slots = 2'(QUEUE_DEPTH) - cnt_r;
  end

  // Frame storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= resp.frame0;
    end
    if (push_n == 2'd2) begin
      q_r[~wr_ptr_r] <= resp.frame1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/steering_lock_can_responder_core.sv
// ----------------------------------------------------------------------------
// steering_lock_can_responder_core
// Steering-lock node responder: restarts its send sequence on a key report
// frame and sends table frames on time updates that reach the deadline.
//
//   channel | direction | handshake             | beat
//   in_     | in        | in_valid / in_ready   | in_beat_t (frame or time update)
//   out_    | out       | out_valid / out_ready | out_beat_t (one frame to send)
//   cfg_    | in        | cfg_we                | cfg_idx, cfg_wdata
//
// One item per cycle while the queue has room: an item is held in the input
// register, then retires into the two-entry result queue, and its first frame
// is shown from the queue register. An update that sends two frames needs both queue
// slots, so an item that sends frames waits until the queue has room.
// Reset is synchronous and clears mode, step, deadline, interval and queue.
// A stall on out_ready fills the queue, then holds the input register.
// ----------------------------------------------------------------------------
module steering_lock_can_responder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  slcr_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output slcr_pkg::out_beat_t            out_data,
  input  logic                           cfg_we,
  input  logic [slcr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [slcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import slcr_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       in_vld_r, in_vld_nxt;
  in_beat_t   in_data_r;
  resp_t      resp;
  logic [1:0] free_slots;
  logic       fits;
  logic       retire;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LISTEN_ID: cfg_nxt.listen_id        = cfg_wdata;
        CFG_SEND_ID:   cfg_nxt.send_id          = cfg_wdata;
        CFG_PRESENT:   cfg_nxt.present_code     = cfg_wdata[7:0];
        CFG_ABSENT:    cfg_nxt.absent_code      = cfg_wdata[7:0];
        CFG_FAST_IVL:  cfg_nxt.fast_interval_ms = cfg_wdata[7:0];
        CFG_SLOW_IVL:  cfg_nxt.slow_interval_ms = cfg_wdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.listen_id        <= RST_LISTEN_ID;
      cfg_r.send_id          <= RST_SEND_ID;
      cfg_r.present_code     <= RST_PRESENT;
      cfg_r.absent_code      <= RST_ABSENT;
      cfg_r.fast_interval_ms <= RST_FAST_IVL;
      cfg_r.slow_interval_ms <= RST_SLOW_IVL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register: retires when the queue has room for its frames
  always_comb begin
    fits       = (resp.cnt <= free_slots);
    retire     = in_vld_r && fits;
    in_ready   = !in_vld_r || fits;
    in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (retire ? 1'b0 : in_vld_r);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  slcr_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (in_data_r),
    .item_go (retire),
    .cfg     (cfg_r),
    .resp    (resp)
  );

  slcr_txq u_txq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (retire),
    .resp       (resp),
    .free_slots (free_slots),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### hw/rtl/slcr_chk.sv
// ----------------------------------------------------------------------------
// slcr_chk
// Port-level checks for the steering-lock responder, bound to the top level.
// ----------------------------------------------------------------------------
module slcr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input slcr_pkg::in_beat_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input slcr_pkg::out_beat_t             out_data,
  input logic                            cfg_we,
  input logic [slcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input logic [slcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import slcr_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The second frame of a pair is queued with the first one
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_frame |=> out_valid && out_data.last_frame)
    else $error("first frame of a pair not followed by its final frame");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset frees the input register
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind steering_lock_can_responder_core slcr_chk u_slcr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_wdata (cfg_wdata)
);
